// ----- src/tcq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcq_pkg: shared definitions for the two-class queue with aging
// Item codes, status codes, field widths and controller/datapath structs.
// ----------------------------------------------------------------------------
package tcq_pkg;

  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int CAP_W   = 11;
  localparam int LEVEL_W = 11;
  localparam int DATA_W  = 64;

  localparam int DEF_QUEUE_DEPTH  = 1024;
  localparam int DEF_PAYLOAD_BITS = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // latch the incoming item
    logic decide;    // evaluate the item, do pushes, start head reads
    logic complete;  // finish a pop or a tick with the head read data
  } tcq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_read;  // the item being decided needs a head word
  } tcq_stat_t;

endpackage : tcq_pkg
`default_nettype wire

// ----- src/tcq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcq_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : tcq_ram
`default_nettype wire

// ----- src/tcq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcq_ctrl: sequencer of the two-class queue
// Steps each item through decide, optional head read, and result cycles.
// ----------------------------------------------------------------------------
module tcq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire tcq_pkg::tcq_stat_t stat,
  output tcq_pkg::tcq_cmd_t       cmd,
  output logic                    busy,
  output logic                    out_valid
);
  import tcq_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign busy      = (state_r == S_DECIDE) || (state_r == S_READ);
  assign out_valid = (state_r == S_OUT);
  assign accept    = start && !busy;

  always_comb begin
    cmd.accept   = accept;
    cmd.decide   = (state_r == S_DECIDE);
    cmd.complete = (state_r == S_READ);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = stat.need_read ? S_READ : S_OUT;
      end
      S_READ: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        state_nxt = accept ? S_DECIDE : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule : tcq_ctrl
`default_nettype wire

// ----- src/tcq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcq_datapath: ring buffers, pointers and result registers
// Holds both queue stores, their heads and fills, the capacity register,
// and the registered result of the current item.
// ----------------------------------------------------------------------------
module tcq_datapath #(
  parameter int QUEUE_DEPTH  = tcq_pkg::DEF_QUEUE_DEPTH,
  parameter int PAYLOAD_BITS = tcq_pkg::DEF_PAYLOAD_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire tcq_pkg::tcq_cmd_t              cmd,
  output tcq_pkg::tcq_stat_t                  stat,
  input  wire logic [tcq_pkg::KIND_W-1:0]     in_kind,
  input  wire logic                           in_is_priority,
  input  wire logic [tcq_pkg::DATA_W-1:0]     in_payload,
  input  wire logic                           cfg_valid,
  input  wire logic [tcq_pkg::CAP_W-1:0]      cfg_data,
  output logic      [tcq_pkg::STAT_W-1:0]     out_status,
  output logic      [tcq_pkg::DATA_W-1:0]     out_pop_data,
  output logic                                out_from_priority,
  output logic      [tcq_pkg::LEVEL_W-1:0]    out_normal_level,
  output logic      [tcq_pkg::LEVEL_W-1:0]    out_priority_level
);
  import tcq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = FW + 1;
  localparam int CW = (FW + 1 > CAP_W) ? FW + 1 : CAP_W;

  // Head plus offset, wrapped once; the sum stays below twice the depth.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] head,
                                             input logic [FW-1:0] offs);
    logic [RW-1:0] sum;
    sum = RW'(head) + RW'(offs);
    if (sum >= RW'(QUEUE_DEPTH)) begin
      sum = sum - RW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] head);
    return (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
  endfunction

  logic [CAP_W-1:0]        cap_r;
  logic [KIND_W-1:0]       kind_r;
  logic                    prio_r;
  logic [PAYLOAD_BITS-1:0] word_r;

  logic [AW-1:0] p_head_r, n_head_r;
  logic [FW-1:0] p_fill_r, n_fill_r;

  logic sel_pop_p_r, sel_pop_n_r, sel_tick_r;

  logic [STAT_W-1:0]       status_r;
  logic [PAYLOAD_BITS-1:0] data_r;
  logic                    from_prio_r;

  logic [PAYLOAD_BITS-1:0] p_rdata, n_rdata;
  logic                    p_we, n_we;
  logic [PAYLOAD_BITS-1:0] p_wdata;
  logic [AW-1:0]           p_tail, n_tail;

  logic [CW-1:0] total, cap_ext, eff_cap;
  logic full, p_empty, n_empty, p_at_depth;
  logic do_push, do_pop_p, do_pop_n, do_tick;
  logic [STAT_W-1:0] status_calc;

  assign cap_ext    = CW'(cap_r);
  assign eff_cap    = (cap_ext > CW'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : cap_ext;
  assign total      = CW'(p_fill_r) + CW'(n_fill_r);
  assign full       = (total >= eff_cap);
  assign p_empty    = (p_fill_r == '0);
  assign n_empty    = (n_fill_r == '0);
  assign p_at_depth = (p_fill_r == FW'(QUEUE_DEPTH));

  assign do_push  = (kind_r == KIND_PUSH) && !full;
  assign do_pop_p = (kind_r == KIND_POP) && !p_empty;
  assign do_pop_n = (kind_r == KIND_POP) && p_empty && !n_empty;
  assign do_tick  = (kind_r == KIND_TICK) && !n_empty && !p_at_depth;

  always_comb begin
    status_calc = ST_DONE;
    unique case (kind_r)
      KIND_PUSH: if (full) status_calc = ST_FULL;
      KIND_POP:  if (p_empty && n_empty) status_calc = ST_EMPTY;
      KIND_TICK: if (n_empty) status_calc = ST_EMPTY;
      default:   status_calc = ST_DONE;
    endcase
  end

  assign stat.need_read = do_pop_p || do_pop_n || do_tick;

  assign p_tail  = ring_add(p_head_r, p_fill_r);
  assign n_tail  = ring_add(n_head_r, n_fill_r);
  assign p_we    = (cmd.decide && do_push && prio_r) || (cmd.complete && sel_tick_r);
  assign n_we    = cmd.decide && do_push && !prio_r;
  assign p_wdata = cmd.complete ? n_rdata : word_r;

  tcq_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_p_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_tail),
    .wdata (p_wdata),
    .raddr (p_head_r),
    .rdata (p_rdata)
  );

  tcq_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_n_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_tail),
    .wdata (word_r),
    .raddr (n_head_r),
    .rdata (n_rdata)
  );

  // Item and result registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_kind;
      prio_r <= in_is_priority;
      word_r <= in_payload[PAYLOAD_BITS-1:0];
    end
    if (cmd.decide) begin
      status_r    <= status_calc;
      data_r      <= '0;
      from_prio_r <= 1'b0;
      sel_pop_p_r <= do_pop_p;
      sel_pop_n_r <= do_pop_n;
      sel_tick_r  <= do_tick;
    end
    if (cmd.complete) begin
      if (sel_pop_p_r) begin
        data_r      <= p_rdata;
        from_prio_r <= 1'b1;
      end else if (sel_pop_n_r) begin
        data_r <= n_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_RESET;
      p_head_r <= '0;
      n_head_r <= '0;
      p_fill_r <= '0;
      n_fill_r <= '0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (cmd.decide && do_push) begin
        if (prio_r) p_fill_r <= p_fill_r + FW'(1);
        else        n_fill_r <= n_fill_r + FW'(1);
      end
      if (cmd.complete) begin
        if (sel_pop_p_r) begin
          p_head_r <= ring_inc(p_head_r);
          p_fill_r <= p_fill_r - FW'(1);
        end else if (sel_pop_n_r) begin
          n_head_r <= ring_inc(n_head_r);
          n_fill_r <= n_fill_r - FW'(1);
        end else if (sel_tick_r) begin
          p_fill_r <= p_fill_r + FW'(1);
          n_head_r <= ring_inc(n_head_r);
          n_fill_r <= n_fill_r - FW'(1);
        end
      end
    end
  end

  assign out_status         = status_r;
  assign out_pop_data       = DATA_W'(data_r);
  assign out_from_priority  = from_prio_r;
  assign out_normal_level   = LEVEL_W'(n_fill_r);
  assign out_priority_level = LEVEL_W'(p_fill_r);

endmodule : tcq_datapath
`default_nettype wire

// ----- src/two_class_queue_with_aging.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_class_queue_with_aging: priority and normal FIFOs with aging promotion
// Two ring-buffer queues that share one capacity limit, served priority first.
// ----------------------------------------------------------------------------
// Usage:
// An item (push, pop or aging tick) is accepted at a rising edge where start
// is high and busy is low. Each item yields exactly one result, shown on the
// out_ ports for a single cycle with out_valid high; the receiver cannot
// stall and must take it in that cycle.
// A push, an unused code, or any item that moves no word goes from the decide
// state straight to the result state. A pop or a tick that moves a word
// passes through a read state between them, because the head word comes
// out of a store RAM with a registered read port.
// Busy drops during the result cycle, so a new item can be taken then; no
// new item is taken while one is still in its decide or read state.
// The capacity register is written through cfg_valid/cfg_data at any edge
// (cfg_ready is always high) and should only change while the block is idle.
// Reset clears heads, fills and the controller and sets capacity to 1024;
// the store contents are left as they are and never read before written.
// ----------------------------------------------------------------------------
module two_class_queue_with_aging #(
  parameter int QUEUE_DEPTH  = tcq_pkg::DEF_QUEUE_DEPTH,
  parameter int PAYLOAD_BITS = tcq_pkg::DEF_PAYLOAD_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [tcq_pkg::KIND_W-1:0]  in_kind,
  input  wire logic                        in_is_priority,
  input  wire logic [tcq_pkg::DATA_W-1:0]  in_payload,
  output logic                             out_valid,
  output logic      [tcq_pkg::STAT_W-1:0]  out_status,
  output logic      [tcq_pkg::DATA_W-1:0]  out_pop_data,
  output logic                             out_from_priority,
  output logic      [tcq_pkg::LEVEL_W-1:0] out_normal_level,
  output logic      [tcq_pkg::LEVEL_W-1:0] out_priority_level,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [tcq_pkg::CAP_W-1:0]   cfg_data
);
  import tcq_pkg::*;

  tcq_cmd_t  cmd;
  tcq_stat_t stat;

  // The capacity register accepts a write in any cycle.
  assign cfg_ready = 1'b1;

  // The controller sequences each item; the datapath owns all queue state.
  tcq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  tcq_datapath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_kind            (in_kind),
    .in_is_priority     (in_is_priority),
    .in_payload         (in_payload),
    .cfg_valid          (cfg_valid && cfg_ready),
    .cfg_data           (cfg_data),
    .out_status         (out_status),
    .out_pop_data       (out_pop_data),
    .out_from_priority  (out_from_priority),
    .out_normal_level   (out_normal_level),
    .out_priority_level (out_priority_level)
  );

endmodule : two_class_queue_with_aging
`default_nettype wire

// ----- src/tcq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcq_checker: port-level checks for the two-class queue
// Watches the command handshake and result strobe of the top level.
// ----------------------------------------------------------------------------
module tcq_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        out_valid,
  input wire logic [tcq_pkg::STAT_W-1:0]  out_status,
  input wire logic [tcq_pkg::DATA_W-1:0]  out_pop_data,
  input wire logic                        out_from_priority
);
  import tcq_pkg::*;

  // An accepted item keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after an accepted item");

  // A result never shows while the block reports itself busy.
  a_result_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Each result strobe lasts one cycle only.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // A failed item returns no data.
  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DONE) |-> (out_pop_data == '0) && !out_from_priority)
    else $error("data returned with a failing status");

endmodule : tcq_checker

bind two_class_queue_with_aging tcq_checker u_tcq_checker (.*);
`default_nettype wire
